### rtl/core/ssbk_pkg.sv
// Shared constants and types for the stable sort-by-key block.
// No dependencies; imported by the top level and the checker.
package ssbk_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 17;
    localparam int PAY_W   = 64;
    localparam int ATOM_W  = 16;
    localparam int FIELD_W = KEY_W + PAY_W;
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_EMIT
    } state_t;

endpackage

### rtl/core/ssbk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssbk_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/stable_sort_by_key.sv
// Stable sort by key: load transactions store records, a start transaction emits them sorted.
// Loads are accepted back to back while idle; no input is taken during a start's run.
// A start over n records, s of them in range: each sorted result and the first filler cost
// one full RAM scan (n reads) plus a drain and an emit state; later fillers need no scan.
// Each emit waits while the output is stalled.
// Reset (rst_n, async, active low) clears entry count, num_atoms and all control; RAMs keep contents.
module stable_sort_by_key
    import ssbk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration: num_atoms
    input  logic               cfg_wr_en,
    input  logic [ATOM_W-1:0]  cfg_wr_data,
    // input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [16:0] key, [80:17] payload, rest zero
    input  logic               s_axis_tuser,   // [0] req_type
    // output stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [16:0] out_key, [80:17] out_payload, rest zero
    output logic               m_axis_tuser,   // [0] is_filler
    output logic               m_axis_tlast    // last
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;        // stored records
    logic [ATOM_W-1:0]   num_atoms_reg;
    logic [ADDR_W-1:0]   scan_addr_reg, scan_addr_next; // read address during scan
    logic                rd_valid_reg;                  // RAM read data is valid
    logic [ADDR_W-1:0]   rd_idx_reg;                    // index of that read data
    logic                found_reg, found_next;         // scan found a candidate
    logic [ATOM_W-1:0]   best_key_reg, best_key_next;
    logic [ADDR_W-1:0]   best_idx_reg, best_idx_next;
    logic [PAY_W-1:0]    best_pay_reg, best_pay_next;
    logic [ATOM_W-1:0]   prev_key_reg, prev_key_next;   // last emitted (key, index)
    logic [ADDR_W-1:0]   prev_idx_reg, prev_idx_next;
    logic                first_reg, first_next;         // no sorted result emitted yet this run
    logic [CNT_W-1:0]    emit_cnt_reg, emit_cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [KEY_W-1:0]    m_key_reg, m_key_next;
    logic [PAY_W-1:0]    m_pay_reg, m_pay_next;
    logic                m_filler_reg, m_filler_next;
    logic                m_last_reg, m_last_next;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic                in_accept;
    logic                in_req;
    logic [KEY_W-1:0]    in_key;
    logic [PAY_W-1:0]    in_pay;
    logic                store_full;
    logic                ram_we;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_req        = s_axis_tuser;
    assign in_key        = s_axis_tdata[KEY_W-1:0];
    assign in_pay        = s_axis_tdata[FIELD_W-1:KEY_W];
    assign store_full    = (count_reg == CNT_W'(DEPTH));
    assign ram_we        = in_accept && (in_req == REQ_LOAD) && !store_full;

    // ------------------------------------------------------------------
    // Record memories: written on load, read sequentially during scan
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] rd_key;
    logic [PAY_W-1:0] rd_pay;

    ssbk_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (in_key),
        .raddr (scan_addr_reg),
        .rdata (rd_key)
    );

    ssbk_ram #(.WIDTH(PAY_W), .DEPTH(DEPTH)) u_pay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (in_pay),
        .raddr (scan_addr_reg),
        .rdata (rd_pay)
    );

    // ------------------------------------------------------------------
    // Scan compare: smallest (key, index) strictly after the last emitted
    // one, among in-range keys. Index rises through the scan, so keeping
    // the first of equal keys gives stable order.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] last_addr;
    logic [CNT_W-1:0]  emit_cnt_inc;
    logic              emit_last;
    logic              out_free;
    logic              rd_in_range;
    logic              rd_after_prev;
    logic              rd_better;
    logic              rd_take;

    assign last_addr     = ADDR_W'(count_reg - CNT_W'(1));
    assign emit_cnt_inc  = emit_cnt_reg + CNT_W'(1);
    assign emit_last     = (emit_cnt_inc == count_reg);
    assign out_free      = !m_valid_reg || m_axis_tready;

    // negative keys have the sign bit set; otherwise compare against num_atoms
    assign rd_in_range   = !rd_key[KEY_W-1] && (rd_key[ATOM_W-1:0] < num_atoms_reg);
    assign rd_after_prev = first_reg
                        || (rd_key[ATOM_W-1:0] > prev_key_reg)
                        || ((rd_key[ATOM_W-1:0] == prev_key_reg) && (rd_idx_reg > prev_idx_reg));
    assign rd_better     = !found_reg || (rd_key[ATOM_W-1:0] < best_key_reg);
    assign rd_take       = rd_valid_reg && rd_in_range && rd_after_prev && rd_better;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_req == REQ_START) && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_addr_reg == last_addr)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (found_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        found_next     = found_reg;
        best_key_next  = best_key_reg;
        best_idx_next  = best_idx_reg;
        best_pay_next  = best_pay_reg;
        prev_key_next  = prev_key_reg;
        prev_idx_next  = prev_idx_reg;
        first_next     = first_reg;
        emit_cnt_next  = emit_cnt_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_key_next     = m_key_reg;
        m_pay_next     = m_pay_reg;
        m_filler_next  = m_filler_reg;
        m_last_next    = m_last_reg;

        if (rd_take)
        begin
            found_next    = 1'b1;
            best_key_next = rd_key[ATOM_W-1:0];
            best_idx_next = rd_idx_reg;
            best_pay_next = rd_pay;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_req == REQ_START)
                    begin
                        scan_addr_next = '0;
                        found_next     = 1'b0;
                        first_next     = 1'b1;
                        emit_cnt_next  = '0;
                    end
                    else if (!store_full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_SCAN:
            begin
                scan_addr_next = scan_addr_reg + ADDR_W'(1);
            end
            ST_SCAN_END:
            begin
                scan_addr_next = '0;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_last_next   = emit_last;
                    emit_cnt_next = emit_cnt_inc;
                    if (found_reg)
                    begin
                        m_key_next     = {1'b0, best_key_reg};
                        m_pay_next     = best_pay_reg;
                        m_filler_next  = 1'b0;
                        prev_key_next  = best_key_reg;
                        prev_idx_next  = best_idx_reg;
                        first_next     = 1'b0;
                        found_next     = 1'b0;
                        scan_addr_next = '0;
                    end
                    else
                    begin
                        // no in-range key left: rest of the run is filler
                        m_key_next    = '0;
                        m_pay_next    = '0;
                        m_filler_next = 1'b1;
                    end
                    if (emit_last)
                    begin
                        count_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            num_atoms_reg <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            first_reg     <= 1'b1;
            emit_cnt_reg  <= '0;
            scan_addr_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            if (cfg_wr_en)
            begin
                num_atoms_reg <= cfg_wr_data;
            end
            rd_valid_reg  <= (state_reg == ST_SCAN);
            found_reg     <= found_next;
            first_reg     <= first_next;
            emit_cnt_reg  <= emit_cnt_next;
            scan_addr_reg <= scan_addr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= scan_addr_reg;
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        best_pay_reg <= best_pay_next;
        prev_key_reg <= prev_key_next;
        prev_idx_reg <= prev_idx_next;
        m_key_reg    <= m_key_next;
        m_pay_reg    <= m_pay_next;
        m_filler_reg <= m_filler_next;
        m_last_reg   <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(TDATA_W - FIELD_W)'(0), m_pay_reg, m_key_reg};
    assign m_axis_tuser  = m_filler_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

### rtl/core/ssbk_checker.sv
// Port-level checks for stable_sort_by_key, attached by bind.
// Depends on ssbk_pkg.
module ssbk_checker
    import ssbk_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser,
    input logic               m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // filler results carry zero key and payload
    a_filler_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("filler result with nonzero data");

    // sorted results never carry a negative key
    a_key_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[KEY_W-1])
        else $error("sorted result with negative key");

    // a filler ends the sorted part: the next result is filler too
    a_filler_tail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast
            ##1 m_axis_tvalid |-> m_axis_tuser)
        else $error("sorted result after filler");

    // input is not taken while a run's result is still pending mid-run
    a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during emit run");

endmodule

bind stable_sort_by_key ssbk_checker u_ssbk_checker (.*);
